[hdl/kcl_pkg.sv]
package kcl_pkg;

  localparam int CODE_LENGTH = 6;
  localparam int KEY_W = 4;
  localparam int PRESET_W = 24;
  localparam int POS_W = $clog2(CODE_LENGTH + 1);
  localparam logic [KEY_W-1:0] MAX_DIGIT = 4'd9;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    PH_UNCHECKED = 2'd0,
    PH_ENROLL    = 2'd1,
    PH_CONFIRM   = 2'd2,
    PH_LOCKED    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OUT_TAKEN    = 3'd0,
    OUT_ENROLLED = 3'd1,
    OUT_MISMATCH = 3'd2,
    OUT_UNLOCKED = 3'd3,
    OUT_WRONG    = 3'd4
  } outcome_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [2:0] keys_entered;
    logic       locked_mode;
  } result_t;

endpackage

[hdl/kcl_intf.sv]
interface kcl_key_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_code;
  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

interface kcl_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  logic [2:0] keys_entered;
  logic       locked_mode;
  modport source (output valid, output outcome, output keys_entered, output locked_mode,
                  input ready);
  modport sink (input valid, input outcome, input keys_entered, input locked_mode,
                output ready);
endinterface

interface kcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] preset_code;
  modport source (output valid, output preset_code, input ready);
  modport sink (input valid, input preset_code, output ready);
endinterface

[hdl/kcl_core.sv]
module kcl_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  kcl_pkg::key_t                       key,
  input  logic [kcl_pkg::PRESET_W-1:0]        preset,
  output kcl_pkg::result_t                    res
);

  localparam int EXT_W = kcl_pkg::PRESET_W + kcl_pkg::KEY_W * kcl_pkg::CODE_LENGTH;

  kcl_pkg::phase_t phase, phase_next, phase_cur;
  kcl_pkg::pos_t   pos, pos_next, pos_cur;
  kcl_pkg::key_t   entry_keys [kcl_pkg::CODE_LENGTH];
  kcl_pkg::key_t   first_entry_keys [kcl_pkg::CODE_LENGTH];
  kcl_pkg::key_t   stored_keys [kcl_pkg::CODE_LENGTH];
  kcl_pkg::key_t   cur_keys [kcl_pkg::CODE_LENGTH];
  kcl_pkg::key_t   ref_keys [kcl_pkg::CODE_LENGTH];
  kcl_pkg::key_t   preset_digit [kcl_pkg::CODE_LENGTH];
  logic [EXT_W-1:0] preset_ext;
  logic            preset_ok;
  logic            load_preset;
  logic            last_key;
  logic            match_first;
  logic            match_ref;
  logic            store_first;
  logic            store_enrolled;
  kcl_pkg::outcome_t outcome;

  assign preset_ext = {{(kcl_pkg::KEY_W * kcl_pkg::CODE_LENGTH){1'b1}}, preset};

  always_comb begin
    preset_ok = 1'b1;
    for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
      preset_digit[i] = preset_ext[i*kcl_pkg::KEY_W +: kcl_pkg::KEY_W];
      if (preset_digit[i] > kcl_pkg::MAX_DIGIT) preset_ok = 1'b0;
    end

    load_preset = 1'b0;
    phase_cur = phase;
    pos_cur = pos;
    if (phase == kcl_pkg::PH_UNCHECKED) begin
      pos_cur = '0;
      if (preset_ok) begin
        phase_cur = kcl_pkg::PH_LOCKED;
        load_preset = 1'b1;
      end else begin
        phase_cur = kcl_pkg::PH_ENROLL;
      end
    end

    match_first = 1'b1;
    match_ref = 1'b1;
    for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
      cur_keys[i] = (pos_cur == kcl_pkg::pos_t'(i)) ? key : entry_keys[i];
      ref_keys[i] = load_preset ? preset_digit[i] : stored_keys[i];
      if (cur_keys[i] != first_entry_keys[i]) match_first = 1'b0;
      if (cur_keys[i] != ref_keys[i]) match_ref = 1'b0;
    end

    last_key = (pos_cur == kcl_pkg::pos_t'(kcl_pkg::CODE_LENGTH - 1));
    phase_next = phase_cur;
    pos_next = pos_cur + kcl_pkg::pos_t'(1);
    outcome = kcl_pkg::OUT_TAKEN;
    store_first = 1'b0;
    store_enrolled = 1'b0;
    if (last_key) begin
      pos_next = '0;
      case (phase_cur)
        kcl_pkg::PH_ENROLL: begin
          store_first = 1'b1;
          phase_next = kcl_pkg::PH_CONFIRM;
        end
        kcl_pkg::PH_CONFIRM: begin
          if (match_first) begin
            store_enrolled = 1'b1;
            phase_next = kcl_pkg::PH_LOCKED;
            outcome = kcl_pkg::OUT_ENROLLED;
          end else begin
            phase_next = kcl_pkg::PH_ENROLL;
            outcome = kcl_pkg::OUT_MISMATCH;
          end
        end
        default: begin
          outcome = match_ref ? kcl_pkg::OUT_UNLOCKED : kcl_pkg::OUT_WRONG;
        end
      endcase
    end

    res.outcome = outcome;
    res.keys_entered = 3'(pos_next);
    res.locked_mode = (phase_next == kcl_pkg::PH_LOCKED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= kcl_pkg::PH_UNCHECKED;
      pos <= '0;
    end else if (advance) begin
      phase <= phase_next;
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
        entry_keys[i] <= cur_keys[i];
        if (store_first) first_entry_keys[i] <= cur_keys[i];
        if (load_preset) stored_keys[i] <= preset_digit[i];
        else if (store_enrolled) stored_keys[i] <= first_entry_keys[i];
      end
    end
  end

endmodule

[hdl/keypad_code_lock.sv]
// Keypad code lock. Each request on key carries one decoded key (0-9 digits, 10 star,
// 11 hash) and yields exactly one request on result with the outcome, the number of
// keys held in the current entry and the locked-mode flag. On the first key after
// reset the preset code register is examined: six valid digits make it the stored
// code, anything else starts enrollment of a code and its confirmation. A key passes
// through an input register, then state update and compare into the result register, so
// one key is accepted every cycle; only a stalled result register holds up new keys. The
// preset is written on cfg at any time but takes effect only at that first key.
module keypad_code_lock (
  input  logic          clk,
  input  logic          rst,
  kcl_key_if.sink       key,
  kcl_result_if.source  result,
  kcl_cfg_if.sink       cfg
);

  logic                          s1_valid;
  kcl_pkg::key_t                 s1_key;
  logic                          out_valid;
  kcl_pkg::result_t              out_res;
  kcl_pkg::result_t              core_res;
  logic                          out_free;
  logic                          advance;
  logic [kcl_pkg::PRESET_W-1:0]  preset;

  assign out_free = !out_valid || result.ready;
  assign advance = s1_valid && out_free;
  assign key.ready = !s1_valid || out_free;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      preset <= '1;
    end else begin
      if (key.ready) s1_valid <= key.valid;
      if (out_free) out_valid <= s1_valid;
      if (cfg.valid) preset <= cfg.preset_code;
    end
  end

  always_ff @(posedge clk) begin
    if (key.valid && key.ready) s1_key <= key.key_code;
    if (advance) out_res <= core_res;
  end

  kcl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .key     (s1_key),
    .preset  (preset),
    .res     (core_res)
  );

  assign result.valid = out_valid;
  assign result.outcome = out_res.outcome;
  assign result.keys_entered = out_res.keys_entered;
  assign result.locked_mode = out_res.locked_mode;

  a_done_in_lock: assert property (@(posedge clk) disable iff (rst)
    result.valid && (out_res.outcome == kcl_pkg::OUT_ENROLLED ||
      out_res.outcome == kcl_pkg::OUT_UNLOCKED || out_res.outcome == kcl_pkg::OUT_WRONG)
    |-> out_res.locked_mode && out_res.keys_entered == 3'd0)
    else $error("completed entry result not in locked mode");

  a_mismatch_unlocked: assert property (@(posedge clk) disable iff (rst)
    result.valid && out_res.outcome == kcl_pkg::OUT_MISMATCH |-> !out_res.locked_mode)
    else $error("confirm mismatch reported in locked mode");

  a_partial_taken: assert property (@(posedge clk) disable iff (rst)
    result.valid && out_res.keys_entered != 3'd0 |-> out_res.outcome == kcl_pkg::OUT_TAKEN)
    else $error("partial entry with final outcome");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> key.ready)
    else $error("key stalled with empty result register");

endmodule

[tb/kcl_lock_checker.sv]
`timescale 1ns / 1ps
module kcl_lock_checker
  import kcl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                key_valid,
  input  logic                key_ready,
  input  key_t                key_code,
  input  logic                res_valid,
  input  logic                res_ready,
  input  logic [2:0]          res_outcome,
  input  logic [2:0]          res_keys_entered,
  input  logic                res_locked_mode,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [PRESET_W-1:0] cfg_preset_code,
  output int                  mismatch_count,
  output int                  results_due
);

  localparam int MAX_REPORTS = 40;

  logic [PRESET_W-1:0] preset_reg;
  phase_t              lock_phase;
  pos_t                entry_pos;
  key_t                entry_buf [CODE_LENGTH];
  key_t                first_buf [CODE_LENGTH];
  key_t                stored_buf[CODE_LENGTH];
  result_t             pending_results[$];
  int                  results_seen;

  function automatic key_t preset_digit(int i);
    if (i >= PRESET_W / KEY_W) return '1;
    return preset_reg[KEY_W*i +: KEY_W];
  endfunction

  function automatic bit entry_matches(bit against_stored);
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entry_buf[i] != (against_stored ? stored_buf[i] : first_buf[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t next_lock_result(key_t k);
    bit       all_digits;
    outcome_t outcome;
    result_t  r;
    outcome = OUT_TAKEN;
    if (lock_phase == PH_UNCHECKED) begin
      all_digits = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        if (preset_digit(i) > MAX_DIGIT) all_digits = 1'b0;
      end
      if (all_digits) begin
        for (int i = 0; i < CODE_LENGTH; i++) stored_buf[i] = preset_digit(i);
        lock_phase = PH_LOCKED;
      end else begin
        lock_phase = PH_ENROLL;
      end
      entry_pos = '0;
    end
    if (entry_pos >= CODE_LENGTH) entry_pos = '0;
    entry_buf[entry_pos] = k;
    entry_pos++;
    if (entry_pos >= CODE_LENGTH) begin
      entry_pos = '0;
      case (lock_phase)
        PH_ENROLL: begin
          for (int i = 0; i < CODE_LENGTH; i++) first_buf[i] = entry_buf[i];
          lock_phase = PH_CONFIRM;
        end
        PH_CONFIRM: begin
          if (entry_matches(1'b0)) begin
            for (int i = 0; i < CODE_LENGTH; i++) stored_buf[i] = first_buf[i];
            lock_phase = PH_LOCKED;
            outcome = OUT_ENROLLED;
          end else begin
            lock_phase = PH_ENROLL;
            outcome = OUT_MISMATCH;
          end
        end
        default: begin
          outcome = entry_matches(1'b1) ? OUT_UNLOCKED : OUT_WRONG;
        end
      endcase
    end
    r.outcome      = outcome;
    r.keys_entered = 3'(entry_pos);
    r.locked_mode  = (lock_phase == PH_LOCKED);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_REPORTS)
      $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      preset_reg = '1;
      lock_phase = PH_UNCHECKED;
      entry_pos  = '0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        entry_buf[i]  = '0;
        first_buf[i]  = '0;
        stored_buf[i] = '0;
      end
      pending_results.delete();
      mismatch_count = 0;
      results_seen   = 0;
    end else begin
      if (cfg_valid && cfg_ready) preset_reg = cfg_preset_code;
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending, outcome", int'(res_outcome), -1);
        end else begin
          want = pending_results.pop_front();
          if (res_outcome !== want.outcome)
            report_mismatch("outcome", int'(res_outcome), int'(want.outcome));
          if (res_keys_entered !== want.keys_entered)
            report_mismatch("keys_entered", int'(res_keys_entered), int'(want.keys_entered));
          if (res_locked_mode !== want.locked_mode)
            report_mismatch("locked_mode", int'(res_locked_mode), int'(want.locked_mode));
        end
        results_seen++;
      end
      if (key_valid && key_ready) pending_results.push_back(next_lock_result(key_code));
    end
    results_due = pending_results.size();
  end

endmodule

[tb/keypad_code_lock_tb.sv]
`timescale 1ns / 1ps
module keypad_code_lock_tb;
  import kcl_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DIRECTED_KEYS  = 24;
  localparam int PHASE_KEYS     = 332;
  localparam logic [PRESET_W-1:0] ENROLL_CODE = 24'h5FBA90;
  localparam logic [PRESET_W-1:0] WRONG_ENTRY = 24'hBA90CF;

  typedef enum int {ENTRY_CODE, ENTRY_RANDOM, ENTRY_NEAR} entry_kind_t;

  logic clk = 1'b0;
  logic rst;
  int   mismatch_count;
  int   results_due;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_reqs;
  int   hold_served;
  int   hold_left;
  int   keys_sent;
  int   quiet_cycles;
  key_t lock_code[CODE_LENGTH];

  kcl_key_if    key_ch();
  kcl_result_if res_ch();
  kcl_cfg_if    cfg_ch();

  always #5 clk = ~clk;

  keypad_code_lock u_top (
    .clk    (clk),
    .rst    (rst),
    .key    (key_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  kcl_lock_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .key_valid        (key_ch.valid),
    .key_ready        (key_ch.ready),
    .key_code         (key_ch.key_code),
    .res_valid        (res_ch.valid),
    .res_ready        (res_ch.ready),
    .res_outcome      (res_ch.outcome),
    .res_keys_entered (res_ch.keys_entered),
    .res_locked_mode  (res_ch.locked_mode),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_preset_code  (cfg_ch.preset_code),
    .mismatch_count   (mismatch_count),
    .results_due      (results_due)
  );

  always @(posedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic key_t any_key();
    if ($urandom_range(15) == 0) return key_t'($urandom_range(15, 12));
    return key_t'($urandom_range(11, 0));
  endfunction

  task automatic send_key(key_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(negedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_code <= k;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    @(negedge clk);
    keys_sent++;
  endtask

  task automatic send_entry(entry_kind_t kind);
    int   flip;
    key_t k;
    flip = $urandom_range(CODE_LENGTH - 1);
    // realign to an entry boundary
    while (keys_sent % CODE_LENGTH != 0) send_key(any_key());
    for (int i = 0; i < CODE_LENGTH; i++) begin
      k = lock_code[i];
      if (kind == ENTRY_RANDOM) k = any_key();
      else if (kind == ENTRY_NEAR && i == flip) k = lock_code[i] ^ key_t'($urandom_range(15, 1));
      send_key(k);
    end
  endtask

  task automatic write_preset(logic [PRESET_W-1:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.preset_code <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    key_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    logic [PRESET_W-1:0] preset;
    int                  r;
    rst                = 1'b1;
    key_ch.valid       = 1'b0;
    key_ch.key_code    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.preset_code = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // only the last preset before the first key counts
    write_preset('0);
    write_preset('1);
    if ($urandom_range(2) == 0) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        lock_code[i] = key_t'($urandom_range(9));
        preset[KEY_W*i +: KEY_W] = lock_code[i];
      end
    end else begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        lock_code[i] = ENROLL_CODE[KEY_W*i +: KEY_W];
        preset[KEY_W*i +: KEY_W] = key_t'($urandom_range(9));
      end
      preset[KEY_W*$urandom_range(CODE_LENGTH - 1) +: KEY_W] = key_t'($urandom_range(15, 10));
    end
    write_preset(preset);
    cfg_ch.valid <= 1'b0;

    // code, wrong entry, then code twice: covers enroll mismatch or unlock and wrong
    send_entry(ENTRY_CODE);
    for (int i = 0; i < CODE_LENGTH; i++) send_key(WRONG_ENTRY[KEY_W*i +: KEY_W]);
    send_entry(ENTRY_CODE);
    send_entry(ENTRY_CODE);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      r = $urandom_range(2);
      write_preset(r == 0 ? '0 : r == 1 ? '1 : PRESET_W'($urandom));
      cfg_ch.valid <= 1'b0;
      while (keys_sent < DIRECTED_KEYS + (ph + 1) * PHASE_KEYS) begin
        if (ph == 0 && hold_reqs == 0 && keys_sent >= DIRECTED_KEYS + 100) hold_reqs++;
        r = $urandom_range(99);
        if (r < 55) send_entry(ENTRY_CODE);
        else if (r < 75) send_entry(ENTRY_NEAR);
        else if (r < 90) send_entry(ENTRY_RANDOM);
        else if (r < 97) repeat ($urandom_range(1, CODE_LENGTH - 1)) send_key(any_key());
        else drain();
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
